@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the collision test block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Types and constants shared by the probe circle collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

   localparam int Z_BITS        = 12;
   localparam int RAD_BITS      = 13;
   localparam int DIST_BITS     = RAD_BITS + 1;
   localparam int DSQ_BITS      = 2 * DIST_BITS;
   localparam int OP_BITS       = 2;
   localparam int PIPE_STAGES   = 6;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = Z_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PROBE_Z_LOW  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROBE_Z_HIGH = 1'b1;

   localparam logic [Z_BITS-1:0] Z_LOW_RESET  = 12'h000;
   localparam logic [Z_BITS-1:0] Z_HIGH_RESET = 12'hFFF;

   typedef enum logic [OP_BITS-1:0] {
      OP_CIRCLE  = 2'd0,
      OP_RECT    = 2'd1,
      OP_SEGMENT = 2'd2
   } op_type;

   // load enables for the two register stages inside one sub-block
   typedef struct packed {
      logic first;
      logic second;
   } pair_en_type;

   // early flags carried from the front stages
   typedef struct packed {
      op_type op;
      logic   zok;
      logic   rfar;
      logic   rin;
   } ctl_type;

   // decision before the wide cross-product compare
   typedef struct packed {
      logic pre_hit;
      logic need_cross;
   } dec_type;

endpackage

`default_nettype wire

@@ rtl/circle_shape_collision_test.sv @@
// ----------------------------------------------------------------------------
// Pipeline: six compute stages plus an output register.
// Throughput: one item per cycle; each stage holds its own valid bit and a stall
// backs up only as far as the first empty stage.
// Reset: synchronous; clears all valid bits, probe_z_low to 0, probe_z_high to 4095.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module circle_shape_collision_test #(
   parameter int COORD_BITS = 15
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [csc_pkg::OP_BITS-1:0]           req_op,
   input  wire logic signed [COORD_BITS-1:0]          req_probe_x,
   input  wire logic signed [COORD_BITS-1:0]          req_probe_y,
   input  wire logic [csc_pkg::RAD_BITS-1:0]          req_probe_radius,
   input  wire logic signed [COORD_BITS-1:0]          req_obj_ax,
   input  wire logic signed [COORD_BITS-1:0]          req_obj_ay,
   input  wire logic signed [COORD_BITS-1:0]          req_obj_bx,
   input  wire logic signed [COORD_BITS-1:0]          req_obj_by,
   input  wire logic [csc_pkg::RAD_BITS-1:0]          req_obj_radius,
   input  wire logic [csc_pkg::Z_BITS-1:0]            req_obj_z_low,
   input  wire logic [csc_pkg::Z_BITS-1:0]            req_obj_z_high,
   input  wire logic                                  req_both_collidable,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   input  wire logic                                  csr_we,
   input  wire logic [csc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [csc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int NS = csc_pkg::PIPE_STAGES;
   localparam int PW = 2 * COORD_BITS + 2;

   // ---------------- configuration ----------------
   logic [csc_pkg::Z_BITS-1:0] probe_z_low_ff, probe_z_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_z_low_ff  <= csc_pkg::Z_LOW_RESET;
         probe_z_high_ff <= csc_pkg::Z_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            csc_pkg::CSR_PROBE_Z_LOW:  probe_z_low_ff  <= csr_wdata[csc_pkg::Z_BITS-1:0];
            csc_pkg::CSR_PROBE_Z_HIGH: probe_z_high_ff <= csr_wdata[csc_pkg::Z_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- valid chain ----------------
   logic [NS-1:0] vld_ff, vld_in, stage_rdy;
   logic          rsp_valid_ff, rsp_hit_ff, out_rdy, hit_in;

   assign out_rdy = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stage_rdy[NS-1] = !vld_ff[NS-1] || out_rdy;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_rdy[k] = !vld_ff[k] || stage_rdy[k+1];
      end
      vld_in[0] = stage_rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = stage_rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (out_rdy) begin
            rsp_valid_ff <= vld_ff[NS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_hit_ff <= hit_in;
      end
   end

   assign req_stall = !stage_rdy[0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ---------------- datapath ----------------
   csc_pkg::pair_en_type en_front, en_reduce, en_wide;

   always_comb begin
      en_front.first   = stage_rdy[0];
      en_front.second  = stage_rdy[1];
      en_reduce.first  = stage_rdy[2];
      en_reduce.second = stage_rdy[3];
      en_wide.first    = stage_rdy[4];
      en_wide.second   = stage_rdy[5];
   end

   logic signed [PW-1:0] pacx2, pacy2, pbcx2, pbcy2, pabx2, paby2;
   logic signed [PW-1:0] pdotx, pdoty, pcrsx, pcrsy;
   logic [csc_pkg::DSQ_BITS-1:0]  dsq2, r2sq2, dsq4;
   logic [csc_pkg::DIST_BITS-1:0] ex2, ey2;
   logic [PW-1:0]                 cr4, len4;
   csc_pkg::ctl_type              ctl2;
   csc_pkg::dec_type              dec4;

   csc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .en              (en_front),
      .op              (req_op),
      .probe_x         (req_probe_x),
      .probe_y         (req_probe_y),
      .probe_radius    (req_probe_radius),
      .obj_ax          (req_obj_ax),
      .obj_ay          (req_obj_ay),
      .obj_bx          (req_obj_bx),
      .obj_by          (req_obj_by),
      .obj_radius      (req_obj_radius),
      .obj_z_low       (req_obj_z_low),
      .obj_z_high      (req_obj_z_high),
      .both_collidable (req_both_collidable),
      .probe_z_low     (probe_z_low_ff),
      .probe_z_high    (probe_z_high_ff),
      .pacx2           (pacx2),
      .pacy2           (pacy2),
      .pbcx2           (pbcx2),
      .pbcy2           (pbcy2),
      .pabx2           (pabx2),
      .paby2           (paby2),
      .pdotx           (pdotx),
      .pdoty           (pdoty),
      .pcrsx           (pcrsx),
      .pcrsy           (pcrsy),
      .dsq             (dsq2),
      .r2sq            (r2sq2),
      .ex              (ex2),
      .ey              (ey2),
      .ctl             (ctl2)
   );

   csc_reduce #(
      .COORD_BITS (COORD_BITS)
   ) u_reduce (
      .clock   (clock),
      .en      (en_reduce),
      .pacx2   (pacx2),
      .pacy2   (pacy2),
      .pbcx2   (pbcx2),
      .pbcy2   (pbcy2),
      .pabx2   (pabx2),
      .paby2   (paby2),
      .pdotx   (pdotx),
      .pdoty   (pdoty),
      .pcrsx   (pcrsx),
      .pcrsy   (pcrsy),
      .dsq     (dsq2),
      .r2sq    (r2sq2),
      .ex      (ex2),
      .ey      (ey2),
      .ctl     (ctl2),
      .cr      (cr4),
      .len2    (len4),
      .dsq_out (dsq4),
      .dec     (dec4)
   );

   csc_wide #(
      .COORD_BITS (COORD_BITS)
   ) u_wide (
      .clock (clock),
      .en    (en_wide),
      .cr    (cr4),
      .len2  (len4),
      .dsq   (dsq4),
      .dec   (dec4),
      .hit   (hit_in)
   );

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted item did not enter stage 1")
   `ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !rsp_valid_ff && !vld_ff[NS-1], !rsp_valid_ff, "result appeared without a valid last stage")
   `ASSERT_IMPLIES(a_full_backpressure, clock, reset, rsp_valid_ff && rsp_stall && (&vld_ff), req_stall, "full pipeline did not stall input")

endmodule

`default_nettype wire

@@ rtl/csc_front.sv @@
// ----------------------------------------------------------------------------
// csc_front
// Stages 1-2: coordinate differences, height check, products and rectangle
// bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front #(
   parameter int COORD_BITS = 15
) (
   input  wire logic                                 clock,
   input  wire csc_pkg::pair_en_type                 en,
   input  wire logic [csc_pkg::OP_BITS-1:0]          op,
   input  wire logic signed [COORD_BITS-1:0]         probe_x,
   input  wire logic signed [COORD_BITS-1:0]         probe_y,
   input  wire logic [csc_pkg::RAD_BITS-1:0]         probe_radius,
   input  wire logic signed [COORD_BITS-1:0]         obj_ax,
   input  wire logic signed [COORD_BITS-1:0]         obj_ay,
   input  wire logic signed [COORD_BITS-1:0]         obj_bx,
   input  wire logic signed [COORD_BITS-1:0]         obj_by,
   input  wire logic [csc_pkg::RAD_BITS-1:0]         obj_radius,
   input  wire logic [csc_pkg::Z_BITS-1:0]           obj_z_low,
   input  wire logic [csc_pkg::Z_BITS-1:0]           obj_z_high,
   input  wire logic                                 both_collidable,
   input  wire logic [csc_pkg::Z_BITS-1:0]           probe_z_low,
   input  wire logic [csc_pkg::Z_BITS-1:0]           probe_z_high,
   output logic signed [2*COORD_BITS+1:0]            pacx2,
   output logic signed [2*COORD_BITS+1:0]            pacy2,
   output logic signed [2*COORD_BITS+1:0]            pbcx2,
   output logic signed [2*COORD_BITS+1:0]            pbcy2,
   output logic signed [2*COORD_BITS+1:0]            pabx2,
   output logic signed [2*COORD_BITS+1:0]            paby2,
   output logic signed [2*COORD_BITS+1:0]            pdotx,
   output logic signed [2*COORD_BITS+1:0]            pdoty,
   output logic signed [2*COORD_BITS+1:0]            pcrsx,
   output logic signed [2*COORD_BITS+1:0]            pcrsy,
   output logic [csc_pkg::DSQ_BITS-1:0]              dsq,
   output logic [csc_pkg::DSQ_BITS-1:0]              r2sq,
   output logic [csc_pkg::DIST_BITS-1:0]             ex,
   output logic [csc_pkg::DIST_BITS-1:0]             ey,
   output csc_pkg::ctl_type                          ctl
);

   localparam int DW   = COORD_BITS + 1;
   localparam int W2   = COORD_BITS + 2;
   localparam int PW   = 2 * COORD_BITS + 2;
   localparam int RW   = (COORD_BITS + 3 > 16) ? COORD_BITS + 3 : 16;
   localparam int DSTW = csc_pkg::DIST_BITS;
   localparam int DSQW = csc_pkg::DSQ_BITS;

   // ---------------- stage 1 ----------------
   logic signed [DW-1:0]  abx_in, aby_in, acx_in, acy_in, bcx_in, bcy_in;
   logic signed [W2-1:0]  rsx, rsy, rsx_neg, rsy_neg;
   logic [DW-1:0]         rdx_in, rdy_in;
   logic [DSTW-1:0]       d_in, r2_in;
   logic                  zok_in;

   logic signed [DW-1:0]  abx1_ff, aby1_ff, acx1_ff, acy1_ff, bcx1_ff, bcy1_ff;
   logic [DW-1:0]         rdx1_ff, rdy1_ff;
   logic [DSTW-1:0]       d1_ff, r2_1_ff;
   logic                  zok1_ff;
   csc_pkg::op_type       op1_ff;

   assign abx_in = DW'(obj_bx) - DW'(obj_ax);
   assign aby_in = DW'(obj_by) - DW'(obj_ay);
   assign acx_in = DW'(probe_x) - DW'(obj_ax);
   assign acy_in = DW'(probe_y) - DW'(obj_ay);
   assign bcx_in = DW'(probe_x) - DW'(obj_bx);
   assign bcy_in = DW'(probe_y) - DW'(obj_by);

   // rectangle test in doubled units: |2p - (lo + hi)|
   assign rsx     = W2'(probe_x) + W2'(probe_x) - W2'(obj_ax) - W2'(obj_bx);
   assign rsy     = W2'(probe_y) + W2'(probe_y) - W2'(obj_ay) - W2'(obj_by);
   assign rsx_neg = -rsx;
   assign rsy_neg = -rsy;
   assign rdx_in  = rsx[W2-1] ? rsx_neg[DW-1:0] : rsx[DW-1:0];
   assign rdy_in  = rsy[W2-1] ? rsy_neg[DW-1:0] : rsy[DW-1:0];

   assign d_in  = DSTW'(probe_radius) + DSTW'(obj_radius);
   assign r2_in = {probe_radius, 1'b0};

   // height ranges overlap, inclusive; an inverted range never overlaps
   assign zok_in = both_collidable
                   && (obj_z_low <= obj_z_high) && (probe_z_low <= probe_z_high)
                   && (obj_z_low <= probe_z_high) && (probe_z_low <= obj_z_high);

   always_ff @(posedge clock) begin
      if (en.first) begin
         abx1_ff <= abx_in;
         aby1_ff <= aby_in;
         acx1_ff <= acx_in;
         acy1_ff <= acy_in;
         bcx1_ff <= bcx_in;
         bcy1_ff <= bcy_in;
         rdx1_ff <= rdx_in;
         rdy1_ff <= rdy_in;
         d1_ff   <= d_in;
         r2_1_ff <= r2_in;
         zok1_ff <= zok_in;
         op1_ff  <= csc_pkg::op_type'(op);
      end
   end

   // ---------------- stage 2 ----------------
   logic signed [RW-1:0] rdx_w, rdy_w, w_w, h_w, r2_w, wr2, hr2, ex_w, ey_w;
   csc_pkg::ctl_type     ctl_in;

   assign rdx_w = RW'(rdx1_ff);
   assign rdy_w = RW'(rdy1_ff);
   assign w_w   = RW'(abx1_ff);
   assign h_w   = RW'(aby1_ff);
   assign r2_w  = RW'(r2_1_ff);
   assign wr2   = w_w + r2_w;
   assign hr2   = h_w + r2_w;
   assign ex_w  = rdx_w - w_w;
   assign ey_w  = rdy_w - h_w;

   always_comb begin
      ctl_in.op   = op1_ff;
      ctl_in.zok  = zok1_ff;
      ctl_in.rfar = (rdx_w > wr2) || (rdy_w > hr2);
      ctl_in.rin  = (rdx_w <= w_w) || (rdy_w <= h_w);
   end

   always_ff @(posedge clock) begin
      if (en.second) begin
         pacx2 <= PW'(acx1_ff) * PW'(acx1_ff);
         pacy2 <= PW'(acy1_ff) * PW'(acy1_ff);
         pbcx2 <= PW'(bcx1_ff) * PW'(bcx1_ff);
         pbcy2 <= PW'(bcy1_ff) * PW'(bcy1_ff);
         pabx2 <= PW'(abx1_ff) * PW'(abx1_ff);
         paby2 <= PW'(aby1_ff) * PW'(aby1_ff);
         pdotx <= PW'(abx1_ff) * PW'(acx1_ff);
         pdoty <= PW'(aby1_ff) * PW'(acy1_ff);
         pcrsx <= PW'(abx1_ff) * PW'(acy1_ff);
         pcrsy <= PW'(aby1_ff) * PW'(acx1_ff);
         dsq   <= DSQW'(d1_ff) * DSQW'(d1_ff);
         r2sq  <= DSQW'(r2_1_ff) * DSQW'(r2_1_ff);
         // only meaningful when the corner test is reached: then 1..2*radius
         ex    <= ex_w[DSTW-1:0];
         ey    <= ey_w[DSTW-1:0];
         ctl   <= ctl_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/csc_reduce.sv @@
// ----------------------------------------------------------------------------
// csc_reduce
// Stages 3-4: dot, cross and distance sums, per-shape decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_reduce #(
   parameter int COORD_BITS = 15
) (
   input  wire logic                          clock,
   input  wire csc_pkg::pair_en_type          en,
   input  wire logic signed [2*COORD_BITS+1:0] pacx2,
   input  wire logic signed [2*COORD_BITS+1:0] pacy2,
   input  wire logic signed [2*COORD_BITS+1:0] pbcx2,
   input  wire logic signed [2*COORD_BITS+1:0] pbcy2,
   input  wire logic signed [2*COORD_BITS+1:0] pabx2,
   input  wire logic signed [2*COORD_BITS+1:0] paby2,
   input  wire logic signed [2*COORD_BITS+1:0] pdotx,
   input  wire logic signed [2*COORD_BITS+1:0] pdoty,
   input  wire logic signed [2*COORD_BITS+1:0] pcrsx,
   input  wire logic signed [2*COORD_BITS+1:0] pcrsy,
   input  wire logic [csc_pkg::DSQ_BITS-1:0]  dsq,
   input  wire logic [csc_pkg::DSQ_BITS-1:0]  r2sq,
   input  wire logic [csc_pkg::DIST_BITS-1:0] ex,
   input  wire logic [csc_pkg::DIST_BITS-1:0] ey,
   input  wire csc_pkg::ctl_type              ctl,
   output logic [2*COORD_BITS+1:0]            cr,
   output logic [2*COORD_BITS+1:0]            len2,
   output logic [csc_pkg::DSQ_BITS-1:0]       dsq_out,
   output csc_pkg::dec_type                   dec
);

   localparam int DPW  = 2 * COORD_BITS + 3;
   localparam int CRW  = 2 * COORD_BITS + 2;
   localparam int DSQW = csc_pkg::DSQ_BITS;
   localparam int CMPW = ((DPW > DSQW) ? DPW : DSQW) + 1;
   localparam int ESW  = DSQW + 1;

   // ---------------- stage 3 ----------------
   logic signed [DPW-1:0]  cdist3_ff, bdist3_ff, dp3_ff, len3_ff, cross3_ff;
   logic [DSQW-1:0]        ex2_3_ff, ey2_3_ff, dsq3_ff, r2sq3_ff;
   csc_pkg::ctl_type       ctl3_ff;

   always_ff @(posedge clock) begin
      if (en.first) begin
         cdist3_ff <= DPW'(pacx2) + DPW'(pacy2);
         bdist3_ff <= DPW'(pbcx2) + DPW'(pbcy2);
         len3_ff   <= DPW'(pabx2) + DPW'(paby2);
         dp3_ff    <= DPW'(pdotx) + DPW'(pdoty);
         cross3_ff <= DPW'(pcrsx) - DPW'(pcrsy);
         ex2_3_ff  <= DSQW'(ex) * DSQW'(ex);
         ey2_3_ff  <= DSQW'(ey) * DSQW'(ey);
         dsq3_ff   <= dsq;
         r2sq3_ff  <= r2sq;
         ctl3_ff   <= ctl;
      end
   end

   // ---------------- stage 4 ----------------
   logic [CMPW-1:0]       dsq_c;
   logic                  chit, bhit, rhit, dp_neg, dp_past, mid, near;
   logic [ESW-1:0]        esum;
   logic signed [DPW-1:0] cross_neg;
   logic [CRW-1:0]        cr_in;
   csc_pkg::dec_type      dec_in;

   assign dsq_c     = CMPW'(dsq3_ff);
   assign chit      = CMPW'($unsigned(cdist3_ff)) <= dsq_c;
   assign bhit      = CMPW'($unsigned(bdist3_ff)) <= dsq_c;
   assign esum      = ESW'(ex2_3_ff) + ESW'(ey2_3_ff);
   assign rhit      = !ctl3_ff.rfar && (ctl3_ff.rin || (esum <= ESW'(r2sq3_ff)));
   assign dp_neg    = dp3_ff[DPW-1] || (dp3_ff == '0);
   assign dp_past   = dp3_ff >= len3_ff;
   // projection falls strictly inside the segment: needs the cross test
   assign mid       = !dp_neg && !dp_past;
   assign near      = dp_neg ? chit : bhit;
   assign cross_neg = -cross3_ff;
   assign cr_in     = cross3_ff[DPW-1] ? cross_neg[CRW-1:0] : cross3_ff[CRW-1:0];

   always_comb begin
      dec_in.pre_hit    = 1'b0;
      dec_in.need_cross = 1'b0;
      case (ctl3_ff.op)
         csc_pkg::OP_CIRCLE: begin
            dec_in.pre_hit = chit;
         end
         csc_pkg::OP_RECT: begin
            dec_in.pre_hit = rhit;
         end
         csc_pkg::OP_SEGMENT: begin
            dec_in.pre_hit    = near && !mid;
            dec_in.need_cross = mid;
         end
         default: begin
            dec_in.pre_hit    = 1'b0;
            dec_in.need_cross = 1'b0;
         end
      endcase
      dec_in.pre_hit    = dec_in.pre_hit && ctl3_ff.zok;
      dec_in.need_cross = dec_in.need_cross && ctl3_ff.zok;
   end

   always_ff @(posedge clock) begin
      if (en.second) begin
         cr      <= cr_in;
         len2    <= len3_ff[CRW-1:0];
         dsq_out <= dsq3_ff;
         dec     <= dec_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/csc_wide.sv @@
// ----------------------------------------------------------------------------
// csc_wide
// Stages 5-6: exact cross^2 <= dist^2 * len^2 compare from split partial
// products.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_wide #(
   parameter int COORD_BITS = 15
) (
   input  wire logic                          clock,
   input  wire csc_pkg::pair_en_type          en,
   input  wire logic [2*COORD_BITS+1:0]       cr,
   input  wire logic [2*COORD_BITS+1:0]       len2,
   input  wire logic [csc_pkg::DSQ_BITS-1:0]  dsq,
   input  wire csc_pkg::dec_type              dec,
   output logic                               hit
);

   localparam int K    = COORD_BITS + 1;
   localparam int PPW  = 2 * K;
   localparam int DSQW = csc_pkg::DSQ_BITS;
   localparam int QW   = K + DSQW;
   localparam int LHW  = 4 * K;
   localparam int RHW  = 2 * K + DSQW;
   localparam int MW   = (LHW > RHW) ? LHW : RHW;

   // ---------------- stage 5: partial products ----------------
   logic [K-1:0]     cr_h, cr_l, len_h, len_l;
   logic [PPW-1:0]   hh5_ff, hl5_ff, ll5_ff;
   logic [QW-1:0]    qh5_ff, ql5_ff;
   csc_pkg::dec_type dec5_ff;

   assign cr_h  = cr[2*K-1:K];
   assign cr_l  = cr[K-1:0];
   assign len_h = len2[2*K-1:K];
   assign len_l = len2[K-1:0];

   always_ff @(posedge clock) begin
      if (en.first) begin
         hh5_ff  <= PPW'(cr_h) * PPW'(cr_h);
         hl5_ff  <= PPW'(cr_h) * PPW'(cr_l);
         ll5_ff  <= PPW'(cr_l) * PPW'(cr_l);
         qh5_ff  <= QW'(len_h) * QW'(dsq);
         ql5_ff  <= QW'(len_l) * QW'(dsq);
         dec5_ff <= dec;
      end
   end

   // ---------------- stage 6: recombine ----------------
   logic [LHW-1:0]   lhs6_ff;
   logic [RHW-1:0]   rhs6_ff;
   csc_pkg::dec_type dec6_ff;

   // cross term appears twice, hence the extra shift
   always_ff @(posedge clock) begin
      if (en.second) begin
         lhs6_ff <= (LHW'(hh5_ff) << (2 * K)) + (LHW'(hl5_ff) << (K + 1)) + LHW'(ll5_ff);
         rhs6_ff <= (RHW'(qh5_ff) << K) + RHW'(ql5_ff);
         dec6_ff <= dec5_ff;
      end
   end

   assign hit = dec6_ff.need_cross ? (MW'(lhs6_ff) <= MW'(rhs6_ff)) : dec6_ff.pre_hit;

endmodule

`default_nettype wire
